FILE: rtl/bscr_pkg.sv
// Shared types, constants and phase tables for the six-step ramp commutator.
package bscr_pkg;

    // PWM resolution and derived duty levels
    localparam int DUTY_BITS  = 10;
    localparam int PWM_FULL   = (1 << DUTY_BITS) - 1;
    localparam int DUTY_FLOOR = PWM_FULL * 60 / 100;
    localparam int DUTY_ALIGN = PWM_FULL * 4 / 10;
    localparam int MAG_SCALE  = 1000;

    // Field widths of the item ports
    localparam int THR_W      = 11;
    localparam int OUT_DUTY_W = 10;
    localparam int HOLD_W     = 20;
    localparam int CH_W       = 3;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // Divider geometry
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 16;

    // Per-mille scaling by reciprocal multiply: mag * RCP_MUL >> RCP_SHIFT
    // equals mag * PWM_FULL / MAG_SCALE exactly for every throttle magnitude
    localparam int     RCP_SHIFT = 29;
    localparam longint RCP_MUL   = ((longint'(1) << RCP_SHIFT) + MAG_SCALE - 1) / MAG_SCALE
                                   * PWM_FULL;
    localparam int     RCP_W     = 30;
    localparam int     SCL_W     = THR_W + RCP_W;

    // Hold times in microseconds
    localparam logic [HOLD_W-1:0] HOLD_ZERO      = 20'd10000;
    localparam logic [HOLD_W-1:0] HOLD_ALIGN     = 20'd800000;
    localparam logic [HOLD_W-1:0] HOLD_FAULT_OFF = 20'd200000;
    localparam logic [HOLD_W-1:0] HOLD_PRECHARGE = 20'd5000;
    localparam logic [HOLD_W-1:0] HOLD_SETTLE    = 20'd1000;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_START    = 16'd5000;
    localparam logic [CFG_W-1:0] RST_END      = 16'd1500;
    localparam logic [CFG_W-1:0] RST_DEC      = 16'd50;
    localparam logic [CFG_W-1:0] RST_INTERVAL = 16'd100;

    // Output action codes
    localparam logic [1:0] ACT_OFF       = 2'd0;
    localparam logic [1:0] ACT_DRIVE     = 2'd1;
    localparam logic [1:0] ACT_PRECHARGE = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START    = 2'd0,
        CFG_END      = 2'd1,
        CFG_DEC      = 2'd2,
        CFG_INTERVAL = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [THR_W-1:0] throttle;
        logic                    safe_mode;
        logic                    driver_fault;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            action;
        logic [CH_W-1:0]       high_channel;
        logic [OUT_DUTY_W-1:0] high_duty;
        logic [CH_W-1:0]       low_channel;
        logic [HOLD_W-1:0]     hold_time;
        logic                  clear_faults;
        logic                  last;
    } t_out_item;

    // Which result the datapath loads into the output register
    typedef enum logic [2:0] {
        EM_HALT,
        EM_ZERO,
        EM_ALIGN,
        EM_DRIVE,
        EM_FOFF,
        EM_PRE,
        EM_SETTLE
    } t_emit;

    typedef struct packed {
        logic  load_in;
        logic  set_halt;
        logic  zero_upd;
        logic  align_upd;
        logic  mul_mag;
        logic  mul_ramp;
        logic  div_start;
        logic  take_target;
        logic  take_duty_div;
        logic  take_duty_tgt;
        logic  drive_upd;
        logic  emit;
        t_emit emit_kind;
        logic  emit_last;
    } t_cmd;

    typedef struct packed {
        logic halt_case;
        logic zero_case;
        logic dir_change;
        logic ramp_active;
        logic fault_hit;
        logic div_done;
        logic slot_free;
    } t_stat;

    // Phase pair of each commutation step; out-of-range steps act as step 0
    function automatic logic [CH_W-1:0] hi_of_step(input logic [2:0] s);
        case (s)
            3'd2, 3'd3: hi_of_step = 3'd4;
            3'd4, 3'd5: hi_of_step = 3'd2;
            default:    hi_of_step = 3'd0;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] lo_of_step(input logic [2:0] s);
        case (s)
            3'd1, 3'd2: lo_of_step = 3'd3;
            3'd3, 3'd4: lo_of_step = 3'd1;
            default:    lo_of_step = 3'd5;
        endcase
    endfunction

endpackage

FILE: rtl/bscr_div.sv
// Restoring unsigned divider, two quotient bits per cycle.
module bscr_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [bscr_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [bscr_pkg::DIV_DEN_W-1:0] i_den,
    output logic                           o_done,
    output logic [bscr_pkg::DIV_NUM_W-1:0] o_quo
);
    import bscr_pkg::*;

    localparam int ITER  = DIV_NUM_W / 2;
    localparam int CNT_W = $clog2(ITER);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   w_s1;
    logic [DIV_DEN_W:0]   w_s2;

    // returns {quotient bit, new remainder}
    function automatic logic [DIV_DEN_W:0] div_step(input logic [DIV_DEN_W-1:0] rem,
                                                    input logic               bit_in,
                                                    input logic [DIV_DEN_W-1:0] den);
        logic [DIV_DEN_W:0] t;
        logic [DIV_DEN_W:0] d;
        t = {rem, bit_in};
        d = {1'b0, den};
        if (t >= d) begin
            div_step = {1'b1, DIV_DEN_W'(t - d)};
        end else begin
            div_step = {1'b0, t[DIV_DEN_W-1:0]};
        end
    endfunction

    assign w_s1 = div_step(r_rem, r_quo[DIV_NUM_W-1], r_den);
    assign w_s2 = div_step(w_s1[DIV_DEN_W-1:0], r_quo[DIV_NUM_W-2], r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ITER - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-3:0], w_s1[DIV_DEN_W], w_s2[DIV_DEN_W]};
            r_rem <= w_s2[DIV_DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/bscr_dp.sv
// Datapath: registers, commutation state, duty arithmetic and output register.
module bscr_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bscr_pkg::t_cmd                  i_cmd,
    output bscr_pkg::t_stat                 o_stat,
    input  bscr_pkg::t_in_item              i_in_item,
    input  logic                            i_cfg_valid,
    input  logic [bscr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bscr_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bscr_pkg::t_out_item             o_out_item
);
    import bscr_pkg::*;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;
    localparam logic [DUTY_BITS-1:0] FULL_V  = DUTY_BITS'(PWM_FULL);
    localparam logic [DUTY_BITS-1:0] FLOOR_V = DUTY_BITS'(DUTY_FLOOR);
    localparam logic [RCP_W-1:0]     RCP_V   = RCP_W'(RCP_MUL);
    localparam int                   TGT_W   = SCL_W - RCP_SHIFT;

    // configuration
    logic [CFG_W-1:0] r_cfg_start;
    logic [CFG_W-1:0] r_cfg_end;
    logic [CFG_W-1:0] r_cfg_dec;
    logic [CFG_W-1:0] r_cfg_interval;

    // commutation state
    logic [2:0]       r_step;
    logic             r_dir;
    logic [1:0]       r_prev_dir;
    logic [CFG_W-1:0] r_period;
    logic [CFG_W-1:0] r_fcnt;
    logic             r_halted;
    logic             r_out_valid;

    // payload
    t_in_item             r_in;
    logic [SCL_W-1:0]     r_scaled;
    logic [DIV_NUM_W-1:0] r_prod;
    logic [DUTY_BITS-1:0] r_target;
    logic [DUTY_BITS-1:0] r_duty;
    t_out_item            r_out;

    logic                 w_neg;
    logic [THR_W-1:0]     w_mag;
    logic [1:0]           w_dir_code;
    logic [CFG_W-1:0]     w_fcnt_inc;
    logic                 w_fire;
    logic                 w_fault;
    logic                 w_ramp;
    logic [2:0]           w_step_next;
    logic [CFG_W-1:0]     w_period_next;
    logic [CFG_W-1:0]     w_gap;
    logic [TGT_W-1:0]     w_tgt_raw;
    logic                 w_div_done;
    logic [DIV_NUM_W-1:0] w_quo;
    t_out_item            w_item;

    assign w_neg      = r_in.throttle[THR_W-1];
    assign w_mag      = w_neg ? $unsigned(-r_in.throttle) : $unsigned(r_in.throttle);
    assign w_dir_code = w_neg ? DIR_REV : DIR_FWD;
    assign w_fcnt_inc = r_fcnt + 1'b1;
    assign w_fire     = w_fcnt_inc >= r_cfg_interval;
    assign w_fault    = w_fire & r_in.driver_fault;
    assign w_ramp     = r_period > r_cfg_end;
    assign w_gap      = r_period - r_cfg_end;
    assign w_tgt_raw  = r_scaled[SCL_W-1:RCP_SHIFT];

    always_comb begin
        if (r_dir) begin
            w_step_next = (r_step == 3'd0 || r_step > 3'd5) ? 3'd5 : r_step - 3'd1;
        end else if (r_step == 3'd5) begin
            w_step_next = 3'd0;
        end else if (r_step > 3'd5) begin
            w_step_next = 3'd1;
        end else begin
            w_step_next = r_step + 3'd1;
        end
        if (!w_ramp) begin
            w_period_next = r_period;
        end else if (w_gap < r_cfg_dec) begin
            w_period_next = r_cfg_end;
        end else begin
            w_period_next = r_period - r_cfg_dec;
        end
    end

    bscr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (r_period),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // result selection
    always_comb begin
        w_item              = '0;
        w_item.last         = i_cmd.emit_last;
        case (i_cmd.emit_kind)
            EM_HALT: begin
                w_item.action = ACT_OFF;
            end
            EM_ZERO: begin
                w_item.action    = ACT_OFF;
                w_item.hold_time = HOLD_ZERO;
            end
            EM_ALIGN: begin
                w_item.action       = ACT_DRIVE;
                w_item.high_channel = hi_of_step(3'd0);
                w_item.low_channel  = lo_of_step(3'd0);
                w_item.high_duty    = OUT_DUTY_W'(DUTY_ALIGN);
                w_item.hold_time    = HOLD_ALIGN;
            end
            EM_DRIVE: begin
                w_item.action       = ACT_DRIVE;
                w_item.high_channel = hi_of_step(r_step);
                w_item.low_channel  = lo_of_step(r_step);
                w_item.high_duty    = OUT_DUTY_W'(r_duty);
                w_item.hold_time    = HOLD_W'(r_period);
            end
            EM_FOFF: begin
                w_item.action    = ACT_OFF;
                w_item.hold_time = HOLD_FAULT_OFF;
            end
            EM_PRE: begin
                w_item.action       = ACT_PRECHARGE;
                w_item.hold_time    = HOLD_PRECHARGE;
                w_item.clear_faults = 1'b1;
            end
            EM_SETTLE: begin
                w_item.action    = ACT_OFF;
                w_item.hold_time = HOLD_SETTLE;
            end
            default: begin
                w_item.action = ACT_OFF;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start    <= RST_START;
            r_cfg_end      <= RST_END;
            r_cfg_dec      <= RST_DEC;
            r_cfg_interval <= RST_INTERVAL;
            r_step         <= 3'd0;
            r_dir          <= 1'b0;
            r_prev_dir     <= DIR_NONE;
            r_period       <= RST_START;
            r_fcnt         <= '0;
            r_halted       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_START:    r_cfg_start    <= i_cfg_data;
                    CFG_END:      r_cfg_end      <= i_cfg_data;
                    CFG_DEC:      r_cfg_dec      <= i_cfg_data;
                    CFG_INTERVAL: r_cfg_interval <= i_cfg_data;
                    default:      r_cfg_start    <= r_cfg_start;
                endcase
            end
            if (i_cmd.set_halt) begin
                r_halted <= 1'b1;
            end
            if (i_cmd.zero_upd) begin
                r_period   <= r_cfg_start;
                r_prev_dir <= DIR_NONE;
                r_step     <= 3'd0;
            end
            if (i_cmd.align_upd) begin
                r_dir      <= w_neg;
                r_prev_dir <= w_dir_code;
                r_period   <= r_cfg_start;
                r_step     <= 3'd0;
            end
            if (i_cmd.drive_upd) begin
                r_step   <= w_step_next;
                r_fcnt   <= w_fire ? '0 : w_fcnt_inc;
                r_period <= w_fault ? r_cfg_start : w_period_next;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_item;
        end
        if (i_cmd.mul_mag) begin
            r_scaled <= SCL_W'(w_mag) * SCL_W'(RCP_V);
        end
        if (i_cmd.mul_ramp) begin
            r_prod <= DIV_NUM_W'(r_target) * DIV_NUM_W'(r_cfg_end);
        end
        if (i_cmd.take_target) begin
            if (w_tgt_raw > TGT_W'(FULL_V)) begin
                r_target <= FULL_V;
            end else if (w_tgt_raw < TGT_W'(FLOOR_V)) begin
                r_target <= FLOOR_V;
            end else begin
                r_target <= w_tgt_raw[DUTY_BITS-1:0];
            end
        end
        if (i_cmd.take_duty_div) begin
            r_duty <= w_quo[DUTY_BITS-1:0];
        end else if (i_cmd.take_duty_tgt) begin
            r_duty <= r_target;
        end
        if (i_cmd.emit) begin
            r_out <= w_item;
        end
    end

    assign o_stat.halt_case   = r_halted | r_in.safe_mode;
    assign o_stat.zero_case   = r_in.throttle == '0;
    assign o_stat.dir_change  = w_dir_code != r_prev_dir;
    assign o_stat.ramp_active = w_ramp;
    assign o_stat.fault_hit   = w_fault;
    assign o_stat.div_done    = w_div_done;
    assign o_stat.slot_free   = !r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: rtl/bscr_ctrl.sv
// Controller: sequences one pass through decision, duty math and result emission.
module bscr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bscr_pkg::t_stat i_stat,
    output bscr_pkg::t_cmd  o_cmd
);
    import bscr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_MUL1,
        S_CLAMP,
        S_TGT,
        S_GO2,
        S_WAIT2,
        S_DRIVE,
        S_FOFF,
        S_FPRE,
        S_FSET
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.halt_case) begin
                    if (i_stat.slot_free) begin
                        w_cmd.emit      = 1'b1;
                        w_cmd.emit_kind = EM_HALT;
                        w_cmd.emit_last = 1'b1;
                        w_cmd.set_halt  = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (i_stat.zero_case) begin
                    if (i_stat.slot_free) begin
                        w_cmd.emit      = 1'b1;
                        w_cmd.emit_kind = EM_ZERO;
                        w_cmd.emit_last = 1'b1;
                        w_cmd.zero_upd  = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (i_stat.dir_change) begin
                    if (i_stat.slot_free) begin
                        w_cmd.emit      = 1'b1;
                        w_cmd.emit_kind = EM_ALIGN;
                        w_cmd.align_upd = 1'b1;
                        n_state         = S_MUL1;
                    end
                end else begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                w_cmd.mul_mag = 1'b1;
                n_state       = S_CLAMP;
            end
            S_CLAMP: begin
                w_cmd.take_target = 1'b1;
                n_state           = S_TGT;
            end
            S_TGT: begin
                if (i_stat.ramp_active) begin
                    w_cmd.mul_ramp = 1'b1;
                    n_state        = S_GO2;
                end else begin
                    w_cmd.take_duty_tgt = 1'b1;
                    n_state             = S_DRIVE;
                end
            end
            S_GO2: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_WAIT2;
            end
            S_WAIT2: begin
                if (i_stat.div_done) begin
                    w_cmd.take_duty_div = 1'b1;
                    n_state             = S_DRIVE;
                end
            end
            S_DRIVE: begin
                if (i_stat.slot_free) begin
                    w_cmd.emit      = 1'b1;
                    w_cmd.emit_kind = EM_DRIVE;
                    w_cmd.emit_last = !i_stat.fault_hit;
                    w_cmd.drive_upd = 1'b1;
                    n_state         = i_stat.fault_hit ? S_FOFF : S_IDLE;
                end
            end
            S_FOFF: begin
                if (i_stat.slot_free) begin
                    w_cmd.emit      = 1'b1;
                    w_cmd.emit_kind = EM_FOFF;
                    n_state         = S_FPRE;
                end
            end
            S_FPRE: begin
                if (i_stat.slot_free) begin
                    w_cmd.emit      = 1'b1;
                    w_cmd.emit_kind = EM_PRE;
                    n_state         = S_FSET;
                end
            end
            S_FSET: begin
                if (i_stat.slot_free) begin
                    w_cmd.emit      = 1'b1;
                    w_cmd.emit_kind = EM_SETTLE;
                    w_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // load only when the port really hands over an item
        w_cmd.load_in = w_cmd.load_in & r_in_ready;
        if (r_state == S_IDLE && !r_in_ready) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_state == S_IDLE;
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = w_cmd;

endmodule

FILE: rtl/bldc_six_step_ramp_commutator_unit.sv
// Top level of the six-step open-loop commutator with start-up period ramp.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready, i_in_item): one item per control
//    pass, carrying throttle, safe-mode request and the driver fault line.
//  - Output channel (o_out_valid / i_out_ready, o_out_item): one to five
//    result items per pass, in order; the final one carries last = 1.
//  - Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data):
//    always ready; write only while no pass is in flight.
//  - One pass at a time: no new item is taken while a pass is in flight.
//    A shutdown or zero-throttle result is emitted from the decision step.
//    A drive result goes through the multiply, clamp and target steps and,
//    with ramp scaling, the divider; the per-mille scaling is a reciprocal
//    multiply, the ramp scaling a divider making two quotient bits a cycle
//    over a 32-bit numerator. Fault handling adds one controller step per
//    extra result.
//  - Results go through a single output register. When the receiver stalls,
//    the controller holds in its current step until the register frees up;
//    no result is dropped, and the next input item is taken after the last
//    result of the current pass has entered the output register.
//  - Reset (i_rst_n low, synchronous) restores register defaults, step 0,
//    no previous direction, period = ramp start, clears halt and the output.
module bldc_six_step_ramp_commutator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bscr_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bscr_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bscr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bscr_pkg::CFG_W-1:0]      i_cfg_data
);
    import bscr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // controller: pass sequencing and result ordering
    bscr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath: config, commutation state, duty math, output register
    bscr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // register writes are always accepted
    assign o_cfg_ready = 1'b1;

endmodule

FILE: rtl/bscr_checker.sv
// Port-level checks for the commutator, bound to the top level.
module bscr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input bscr_pkg::t_out_item o_out_item
);
    import bscr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // one pass at a time: no back-to-back input acceptance
    a_one_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a pass is in flight");

    // a driven pair never shorts a phase to itself
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.action == ACT_DRIVE |->
            o_out_item.high_channel != o_out_item.low_channel)
        else $error("high and low side on the same channel");

    // fault clear only during precharge, which is never the final result
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.clear_faults |->
            o_out_item.action == ACT_PRECHARGE && !o_out_item.last)
        else $error("clear_faults outside the precharge result");

endmodule

bind bldc_six_step_ramp_commutator_unit bscr_checker u_bscr_checker (.*);

FILE: tb/bldc_six_step_ramp_commutator_unit_tb.sv
// Self-checking testbench of the six-step ramp commutator: random and directed passes.
module bldc_six_step_ramp_commutator_unit_tb;
    import bscr_pkg::*;

    // Direction codes of the last driven pass
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // Phase pair of each commutation step
    localparam logic [2:0] HI_TAB [0:5] = '{3'd0, 3'd0, 3'd4, 3'd4, 3'd2, 3'd2};
    localparam logic [2:0] LO_TAB [0:5] = '{3'd5, 3'd3, 3'd3, 3'd1, 3'd1, 3'd5};

    localparam int DRAIN_CYCLES = 50;   // idle time after the last result of a phase
    localparam int LONG_STALL   = 300;  // receiver hold-off, long enough to back up input

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_START;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    bldc_six_step_ramp_commutator_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the commutator: registers and state
    // ------------------------------------------------------------------
    logic [15:0] cfg_start    = RST_START;
    logic [15:0] cfg_end      = RST_END;
    logic [15:0] cfg_dec      = RST_DEC;
    logic [15:0] cfg_interval = RST_INTERVAL;

    logic [2:0]  step_q     = 3'd0;
    logic        rot_rev    = 1'b0;
    logic [1:0]  prev_dir   = DIR_NONE;
    logic [15:0] period     = RST_START;
    logic [15:0] chk_count  = 16'd0;
    logic        halted     = 1'b0;

    t_out_item expected_out [$];   // results still owed by the block, oldest first
    t_in_item  pass_queue   [$];   // passes waiting to be offered

    int push_cnt = 0;   // passes queued so far
    int acc_cnt  = 0;   // passes accepted by the block
    int res_cnt  = 0;   // results checked
    int err_cnt  = 0;
    int run_dir  = 1;   // direction of the current random run
    logic in_taken = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        err_cnt++;
        $display("mismatch %0d at %0t: %s", err_cnt, $realtime, msg);
    endtask

    function automatic t_out_item mk_out(input logic [1:0] act, input logic [2:0] hi,
                                         input logic [9:0] duty, input logic [2:0] lo,
                                         input logic [19:0] hold, input logic clr);
        t_out_item r;
        r.action       = act;
        r.high_channel = hi;
        r.high_duty    = duty;
        r.low_channel  = lo;
        r.hold_time    = hold;
        r.clear_faults = clr;
        r.last         = 1'b0;
        return r;
    endfunction

    // Works out every result of one control pass and advances the shadow state
    task automatic predict_pass(input t_in_item it);
        t_out_item   res [$];
        t_out_item   r;
        int          thr;
        int          s;
        int unsigned mag;
        int unsigned target;
        int unsigned duty;
        logic [1:0]  dir_code;
        thr = $signed(it.throttle);
        if (halted || it.safe_mode) begin
            // shutdown latches until reset
            halted = 1'b1;
            res.push_back(mk_out(ACT_OFF, 3'd0, 10'd0, 3'd0, 20'd0, 1'b0));
        end else if (thr == 0) begin
            period   = cfg_start;
            prev_dir = DIR_NONE;
            step_q   = 3'd0;
            res.push_back(mk_out(ACT_OFF, 3'd0, 10'd0, 3'd0, HOLD_ZERO, 1'b0));
        end else begin
            dir_code = (thr > 0) ? DIR_FWD : DIR_REV;
            mag      = (thr > 0) ? thr : -thr;
            if (dir_code != prev_dir) begin
                // align on step 0 before driving the new direction
                rot_rev  = (thr < 0);
                prev_dir = dir_code;
                period   = cfg_start;
                res.push_back(mk_out(ACT_DRIVE, HI_TAB[0], DUTY_ALIGN[9:0], LO_TAB[0],
                                     HOLD_ALIGN, 1'b0));
                step_q = 3'd0;
            end
            target = mag * PWM_FULL / MAG_SCALE;
            if (target > PWM_FULL) target = PWM_FULL;
            if (target < DUTY_FLOOR) target = DUTY_FLOOR;
            // duty shrinks by end/period while the ramp is still running
            if (period > cfg_end) duty = target * cfg_end / period;
            else                  duty = target;
            s = (step_q < 3'd6) ? step_q : 0;
            res.push_back(mk_out(ACT_DRIVE, HI_TAB[s], duty[9:0], LO_TAB[s],
                                 {4'd0, period}, 1'b0));
            s = rot_rev ? (s + 5) % 6 : (s + 1) % 6;
            step_q = s[2:0];
            if (period > cfg_end) begin
                if (period - cfg_end < cfg_dec) period = cfg_end;
                else                            period = period - cfg_dec;
            end
            chk_count = chk_count + 16'd1;
            if (chk_count >= cfg_interval) begin
                chk_count = 16'd0;
                if (it.driver_fault) begin
                    res.push_back(mk_out(ACT_OFF, 3'd0, 10'd0, 3'd0, HOLD_FAULT_OFF, 1'b0));
                    res.push_back(mk_out(ACT_PRECHARGE, 3'd0, 10'd0, 3'd0, HOLD_PRECHARGE,
                                         1'b1));
                    res.push_back(mk_out(ACT_OFF, 3'd0, 10'd0, 3'd0, HOLD_SETTLE, 1'b0));
                    period = cfg_start;
                end
            end
        end
        foreach (res[i]) begin
            r      = res[i];
            r.last = (i == res.size() - 1);
            expected_out.push_back(r);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_out.size() == 0) begin
            note_mismatch($sformatf("result %h with nothing pending", got));
            return;
        end
        want = expected_out.pop_front();
        res_cnt++;
        if (got.action !== want.action)
            note_mismatch($sformatf("res %0d action %0d want %0d",
                                    res_cnt, got.action, want.action));
        if (got.high_channel !== want.high_channel)
            note_mismatch($sformatf("res %0d high_channel %0d want %0d",
                                    res_cnt, got.high_channel, want.high_channel));
        if (got.high_duty !== want.high_duty)
            note_mismatch($sformatf("res %0d high_duty %0d want %0d",
                                    res_cnt, got.high_duty, want.high_duty));
        if (got.low_channel !== want.low_channel)
            note_mismatch($sformatf("res %0d low_channel %0d want %0d",
                                    res_cnt, got.low_channel, want.low_channel));
        if (got.hold_time !== want.hold_time)
            note_mismatch($sformatf("res %0d hold_time %0d want %0d",
                                    res_cnt, got.hold_time, want.hold_time));
        if (got.clear_faults !== want.clear_faults)
            note_mismatch($sformatf("res %0d clear_faults %b want %b",
                                    res_cnt, got.clear_faults, want.clear_faults));
        if (got.last !== want.last)
            note_mismatch($sformatf("res %0d last %b want %b", res_cnt, got.last, want.last));
    endtask

    // Monitor: predicts on every accepted pass, checks every accepted result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                predict_pass(i_in_item);
                acc_cnt++;
            end
            if (o_out_valid && i_out_ready) check_result(o_out_item);
        end
    end

    // Idle rates follow progress: sender-light first, then receiver-light, then none
    function automatic int sender_idle_pct();
        if (acc_cnt < 140) return 29;
        if (acc_cnt < 280) return 69;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (acc_cnt < 140) return 69;
        if (acc_cnt < 280) return 29;
        return 0;
    endfunction

    // Driver: offers the next pass once the previous one is gone
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pass_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
                i_in_item  <= pass_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus two long hold-offs that back up the input
    int stall_left    = 0;
    int next_stall_at = 40;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (acc_cnt >= next_stall_at) begin
            stall_left    = LONG_STALL;
            next_stall_at = (next_stall_at < 300) ? 320 : 1_000_000;
            i_out_ready  <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    function automatic t_in_item mk_in(input int thr, input logic sm, input logic df);
        t_in_item it;
        it.throttle     = thr[THR_W-1:0];
        it.safe_mode    = sm;
        it.driver_fault = df;
        return it;
    endfunction

    task automatic offer(input t_in_item it);
        pass_queue.push_back(it);
        push_cnt++;
    endtask

    // Mostly runs in one direction so the ramp gets going; some stops and reversals
    task automatic queue_random(input int n, input bit with_safe);
        int r;
        int mag;
        int thr;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 6) begin
                thr = 0;
            end else begin
                if (r < 14) run_dir = -run_dir;
                if (r < 18)      mag = $urandom_range(1) ? 1000 : $urandom_range(3, 1);
                else if (r < 20) mag = $urandom_range(1024, 1001);
                else             mag = $urandom_range(1000, 1);
                thr = run_dir * mag;
                if (thr > 1023) thr = 1023;
            end
            offer(mk_in(thr, with_safe ? 1'($urandom_range(1)) : 1'b0,
                        1'($urandom_range(1))));
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_START:    cfg_start    = val;
            CFG_END:      cfg_end      = val;
            CFG_DEC:      cfg_dec      = val;
            CFG_INTERVAL: cfg_interval = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] st, input logic [15:0] en,
                             input logic [15:0] dc, input logic [15:0] iv);
        write_reg(CFG_START, st);
        write_reg(CFG_END, en);
        write_reg(CFG_DEC, dc);
        write_reg(CFG_INTERVAL, iv);
    endtask

    // Sender pause: everything offered is taken and every result has come back
    task automatic drain();
        do @(negedge i_clk); while (!(acc_cnt == push_cnt && expected_out.size() == 0));
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: stop, full throttle, floor, saturation, reversal, restart
        @(posedge i_clk);
        offer(mk_in(0, 1'b0, 1'b0));
        offer(mk_in(1000, 1'b0, 1'b1));
        offer(mk_in(1000, 1'b0, 1'b0));
        offer(mk_in(500, 1'b0, 1'b0));     // below the duty floor
        offer(mk_in(1, 1'b0, 1'b1));
        offer(mk_in(600, 1'b0, 1'b0));
        offer(mk_in(1023, 1'b0, 1'b0));    // saturates at full scale
        offer(mk_in(-1024, 1'b0, 1'b0));   // reversal, realign
        offer(mk_in(-1000, 1'b0, 1'b0));
        offer(mk_in(-1, 1'b0, 1'b1));
        offer(mk_in(-800, 1'b0, 1'b0));
        offer(mk_in(-900, 1'b0, 1'b0));
        offer(mk_in(0, 1'b0, 1'b0));
        offer(mk_in(-700, 1'b0, 1'b0));    // same sign after stop still realigns
        offer(mk_in(999, 1'b0, 1'b0));
        offer(mk_in(850, 1'b0, 1'b0));
        drain();

        // Extremes: huge start period, tiny end, one-step ramp, check every pass
        write_all(16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
        @(posedge i_clk);
        offer(mk_in(1000, 1'b0, 1'b1));    // fault on the first pass
        offer(mk_in(1000, 1'b0, 1'b0));
        offer(mk_in(-500, 1'b0, 1'b1));
        offer(mk_in(-500, 1'b0, 1'b0));
        offer(mk_in(0, 1'b0, 1'b1));
        queue_random(40, 1'b0);
        drain();

        // Other extremes: no ramp scaling, no decrement, almost no fault checks
        write_all(16'd1, 16'hFFFF, 16'd0, 16'hFFFF);
        @(posedge i_clk);
        queue_random(30, 1'b0);
        drain();

        // Zero start period and zero check interval
        write_all(16'd0, 16'($urandom_range(3000, 1)), 16'($urandom_range(400)), 16'd0);
        @(posedge i_clk);
        queue_random(30, 1'b0);
        drain();

        // Assorted settings, short fault intervals so faults come up often
        for (int p = 0; p < 6; p++) begin
            write_all(16'($urandom_range(9000, 200)), 16'($urandom_range(6000, 100)),
                      16'($urandom_range(600)),
                      (p == 2) ? 16'($urandom_range(200, 7)) : 16'($urandom_range(6, 1)));
            @(posedge i_clk);
            queue_random(45, 1'b0);
            drain();
        end

        // Shutdown last: after it every pass answers all-off until reset
        @(posedge i_clk);
        queue_random(6, 1'b0);
        offer(mk_in(700, 1'b1, 1'b0));
        offer(mk_in(0, 1'b1, 1'b1));
        queue_random(10, 1'b1);
        drain();

        if (err_cnt == 0) $display("PASS");
        else              $display("FAIL");
        $finish;
    end

endmodule
